// File: rtl/dcw_pkg.sv
package dcw_pkg;

  // opcodes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_NULL_OFS = 2'd0;
  localparam logic [1:0] REG_LVDT_OFS = 2'd1;
  localparam logic [1:0] REG_AXIS_ONE = 2'd2;
  localparam logic [1:0] REG_AXIS_TWO = 2'd3;

  localparam int MID_CODE    = 8192;
  localparam int MID_SHIFT   = 13;
  localparam int MV_FULL     = 10000;
  localparam int CODE_PER_V  = 819;
  localparam int MV_PER_V    = 1000;
  localparam logic [14:0] UPDATE_BIT = 15'h4000;

  // millivolt values and code sums, sized for the widest allowed code
  localparam int MV_W  = 18;
  localparam int SUM_W = 19;
  localparam int Q_W   = 18;

  // reciprocal of 1000 for the mv to counts conversion
  localparam int RECIP_SHIFT = 37;
  localparam logic [27:0] RECIP = 28'((64'd1 << RECIP_SHIFT) / MV_PER_V);

  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic               op;
    logic               bad;
    logic               axis;
    logic [2:0]         slot;
    logic signed [15:0] value;
    logic               volt;
    logic               inc;
  } cmd_t;

  typedef struct packed {
    logic               spi_send;
    logic [14:0]        spi_word;
    logic [3:0]         slave_select;
    logic signed [14:0] read_value;
    logic               status;
  } res_t;

endpackage

// File: rtl/dcw_front.sv
module dcw_front #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic               op_i,
  input  logic [2:0]         channel_i,
  input  logic signed [15:0] value_i,
  input  logic               volt_i,
  input  logic               inc_i,
  input  logic [2:0]         axis_one_i,
  input  logic [2:0]         axis_two_i,
  input  logic               full_i,
  output logic               push_o,
  output dcw_pkg::cmd_t      cmd_o
);

  logic bad;

  // channel numbers count from one
  assign bad = (channel_i == 3'd0) || (32'(channel_i) > NUM_CHANNELS);

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = op_i;
    cmd_o.bad   = bad;
    cmd_o.axis  = !bad && ((channel_i == axis_one_i) || (channel_i == axis_two_i));
    cmd_o.slot  = channel_i - 3'd1;
    cmd_o.value = value_i;
    cmd_o.volt  = volt_i;
    cmd_o.inc   = inc_i;
  end

endmodule

// File: rtl/dcw_fifo.sv
module dcw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcw_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dcw_pkg::cmd_t data_o
);

  localparam int PTR_W = (dcw_pkg::FIFO_DEPTH > 1) ? $clog2(dcw_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(dcw_pkg::FIFO_DEPTH + 1);

  dcw_pkg::cmd_t mem_q [dcw_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(dcw_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == dcw_pkg::FIFO_DEPTH - 1) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  always_comb begin
    wptr_d = do_push ? next_ptr(wptr_q) : wptr_q;
    rptr_d = do_pop ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/dcw_m2c.sv
// millivolts to counts: 819 * mv / 1000, truncated toward zero
module dcw_m2c (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [dcw_pkg::MV_W-1:0]   mv_i,
  output logic                              done_o,
  output logic signed [dcw_pkg::Q_W-1:0]    q_o
);

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_RECIP = 2'd1;
  localparam logic [1:0] M_BACK  = 2'd2;
  localparam logic [1:0] M_FIX   = 2'd3;

  logic [1:0]  st_q, st_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic [26:0] a_q, a_d;
  logic [54:0] p_q, p_d;
  logic [17:0] qe_q, qe_d;
  logic [27:0] m_q, m_d;
  logic signed [dcw_pkg::Q_W-1:0] q_q, q_d;
  logic [17:0] mag;
  logic [27:0] rem;
  logic [17:0] qfix;

  assign mag    = mv_i[dcw_pkg::MV_W-1] ? 18'(-mv_i) : 18'(mv_i);
  assign rem    = 28'(a_q) - m_q;
  // the reciprocal estimate is low by at most one
  assign qfix   = (rem >= 28'(dcw_pkg::MV_PER_V)) ? qe_q + 18'd1 : qe_q;
  assign done_o = done_q;
  assign q_o    = q_q;

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    a_d    = a_q;
    p_d    = p_q;
    qe_d   = qe_q;
    m_d    = m_q;
    q_d    = q_q;
    case (st_q)
      M_IDLE: begin
        if (start_i) begin
          neg_d = mv_i[dcw_pkg::MV_W-1];
          a_d   = 27'(mag) * 27'(dcw_pkg::CODE_PER_V);
          st_d  = M_RECIP;
        end
      end
      M_RECIP: begin
        p_d  = 55'(a_q) * 55'(dcw_pkg::RECIP);
        st_d = M_BACK;
      end
      M_BACK: begin
        qe_d = p_q[54:dcw_pkg::RECIP_SHIFT];
        m_d  = 28'(p_q[54:dcw_pkg::RECIP_SHIFT]) * 28'(dcw_pkg::MV_PER_V);
        st_d = M_FIX;
      end
      M_FIX: begin
        q_d    = neg_q ? -$signed(qfix) : $signed(qfix);
        done_d = 1'b1;
        st_d   = M_IDLE;
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    a_q   <= a_d;
    p_q   <= p_d;
    qe_q  <= qe_d;
    m_q   <= m_d;
    q_q   <= q_d;
  end

endmodule

// File: rtl/dcw_back.sv
module dcw_back #(
  parameter int NUM_CHANNELS = 4,
  parameter int DAC_MAX      = 16383
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  dcw_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  input  logic signed [14:0]  null_ofs_i,
  input  logic signed [14:0]  lvdt_ofs_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcw_pkg::res_t       res_o
);

  localparam int CODE_W = $clog2(DAC_MAX + 1);
  localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic signed [dcw_pkg::SUM_W-1:0] LIM = dcw_pkg::SUM_W'(DAC_MAX);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CONV  = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_OFS1  = 3'd5;
  localparam logic [2:0] ST_OFS2  = 3'd6;

  logic [CODE_W-1:0] codes_q [NUM_CHANNELS];

  logic [2:0]          st_q, st_d;
  dcw_pkg::cmd_t       cmd_q, cmd_d;
  logic [CODE_W-1:0]   cur_q, cur_d;
  logic [CODE_W-1:0]   ccode_q, ccode_d;
  logic signed [31:0]  prod_q, prod_d;
  logic signed [dcw_pkg::SUM_W-1:0] acc_q, acc_d;
  logic signed [dcw_pkg::MV_W-1:0]  mvop_q, mvop_d;
  logic                start_q, start_d;
  logic                out_valid_q, out_valid_d;
  dcw_pkg::res_t       res_q, res_d;

  logic                wr_en;
  logic [CODE_W-1:0]   wr_code;
  logic                m2c_done;
  logic signed [dcw_pkg::Q_W-1:0] m2c_q;

  logic [15:0]         code_ext;
  logic [7:0]          sel_sh;
  logic signed [17:0]  cdiff;
  logic signed [31:0]  mv_full;
  logic signed [dcw_pkg::MV_W-1:0] mv_rd;
  logic [CODE_W-1:0]   fin_code;

  dcw_m2c u_m2c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .mv_i   (mvop_q),
    .done_o (m2c_done),
    .q_o    (m2c_q)
  );

  function automatic logic [CODE_W-1:0] clamp_code(
    input logic signed [dcw_pkg::SUM_W-1:0] v
  );
    logic [CODE_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > LIM) r = CODE_W'(DAC_MAX);
    else r = v[CODE_W-1:0];
    return r;
  endfunction

  assign sel_sh  = 8'd1 << cmd_q.slot;
  assign cdiff   = $signed(18'(cur_q)) - 18'sd8192;
  // divide by 8192 rounding toward zero
  assign mv_full = (prod_q + ((prod_q < 0) ? 32'sd8191 : 32'sd0)) >>> dcw_pkg::MID_SHIFT;
  assign mv_rd   = mv_full[dcw_pkg::MV_W-1:0];

  always_comb begin
    if (st_q == ST_OFS2) fin_code = clamp_code(acc_q + dcw_pkg::SUM_W'(m2c_q));
    else fin_code = clamp_code(acc_q);
  end
  assign code_ext = 16'(fin_code);

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    ccode_d     = ccode_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    mvop_d      = mvop_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    wr_code     = fin_code;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || out_ready_i)) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          cur_d = cmd_i.bad ? '0 : codes_q[cmd_i.slot[SLOT_W-1:0]];
          if (cmd_i.bad) begin
            res_d        = '0;
            res_d.status = 1'b1;
            out_valid_d  = 1'b1;
          end else if (cmd_i.op == dcw_pkg::OP_READ && !cmd_i.volt) begin
            res_d            = '0;
            res_d.read_value = $signed(15'(cur_d));
            out_valid_d      = 1'b1;
          end else if (cmd_i.volt && (cmd_i.op == dcw_pkg::OP_READ || cmd_i.inc)) begin
            st_d = ST_MUL;
          end else if (cmd_i.volt) begin
            mvop_d  = dcw_pkg::MV_W'(cmd_i.value);
            start_d = 1'b1;
            st_d    = ST_CONV;
          end else begin
            acc_d = dcw_pkg::SUM_W'(cmd_i.value)
                  + (cmd_i.inc ? $signed(dcw_pkg::SUM_W'(cur_d)) : '0);
            st_d  = ST_CLAMP;
          end
        end
      end
      ST_MUL: begin
        prod_d = 32'(cdiff) * 32'sd10000;
        st_d   = ST_DIV;
      end
      ST_DIV: begin
        if (cmd_q.op == dcw_pkg::OP_READ) begin
          res_d            = '0;
          res_d.read_value = mv_rd[14:0];
          out_valid_d      = 1'b1;
          st_d             = ST_IDLE;
        end else begin
          mvop_d  = dcw_pkg::MV_W'(cmd_q.value) + mv_rd;
          start_d = 1'b1;
          st_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (m2c_done) begin
          acc_d = dcw_pkg::SUM_W'(dcw_pkg::MID_CODE) + dcw_pkg::SUM_W'(m2c_q);
          st_d  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        wr_en   = 1'b1;
        ccode_d = fin_code;
        if (cmd_q.axis) begin
          mvop_d  = dcw_pkg::MV_W'(null_ofs_i);
          start_d = 1'b1;
          st_d    = ST_OFS1;
        end else begin
          res_d              = '0;
          res_d.spi_send     = 1'b1;
          res_d.spi_word     = code_ext[14:0] | dcw_pkg::UPDATE_BIT;
          res_d.slave_select = sel_sh[3:0];
          out_valid_d        = 1'b1;
          st_d               = ST_IDLE;
        end
      end
      ST_OFS1: begin
        if (m2c_done) begin
          acc_d   = $signed(dcw_pkg::SUM_W'(ccode_q)) + dcw_pkg::SUM_W'(m2c_q);
          mvop_d  = dcw_pkg::MV_W'(lvdt_ofs_i);
          start_d = 1'b1;
          st_d    = ST_OFS2;
        end
      end
      ST_OFS2: begin
        if (m2c_done) begin
          res_d              = '0;
          res_d.spi_send     = 1'b1;
          res_d.spi_word     = code_ext[14:0] | dcw_pkg::UPDATE_BIT;
          res_d.slave_select = sel_sh[3:0];
          out_valid_d        = 1'b1;
          st_d               = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        codes_q[i] <= '0;
      end
    end else begin
      st_q        <= st_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        codes_q[cmd_q.slot[SLOT_W-1:0]] <= wr_code;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cur_q   <= cur_d;
    ccode_q <= ccode_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    mvop_q  <= mvop_d;
    res_q   <= res_d;
  end

endmodule

// File: rtl/dac_channel_writer.sv
// Four-channel DAC front end. Each input beat is a write or a read-back of one
// channel and gives exactly one result beat, in order. Beats enter a two-entry
// command queue, so the input side takes up to two beats while the executing
// side works or a finished result waits on the output register. The executing
// side handles one command at a time: a bad channel or raw read-back is
// answered from idle, a raw write is clamped, a millivolt read-back goes
// through a multiply and a divide, a millivolt write through a conversion
// (after both if incremental); an axis channel adds two offset conversions.
// The shared mv-to-count unit runs four steps through a reciprocal multiply.
module dac_channel_writer #(
  parameter int NUM_CHANNELS = 4,
  parameter int DAC_MAX      = 16383
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // channel[2:0], value[18:3], zero
  input  logic [2:0]  s_axis_tuser,  // operation, value_is_voltage, incremental
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // spi_word[14:0], slave_select[18:15],
                                     // read_value[33:19], zero
  output logic [1:0]  m_axis_tuser   // spi_send, status
);

  logic signed [14:0] null_q, lvdt_q;
  logic [2:0]         axis_one_q, axis_two_q;
  logic               cfg_wr;

  logic               push, full, pop, cmd_valid;
  dcw_pkg::cmd_t      cmd_in, cmd_out;
  dcw_pkg::res_t      res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      null_q     <= '0;
      lvdt_q     <= '0;
      axis_one_q <= 3'd1;
      axis_two_q <= 3'd2;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dcw_pkg::REG_NULL_OFS: null_q     <= $signed(pwdata[14:0]);
        dcw_pkg::REG_LVDT_OFS: lvdt_q     <= $signed(pwdata[14:0]);
        dcw_pkg::REG_AXIS_ONE: axis_one_q <= pwdata[2:0];
        dcw_pkg::REG_AXIS_TWO: axis_two_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dcw_pkg::REG_NULL_OFS: prdata = 32'(null_q);
      dcw_pkg::REG_LVDT_OFS: prdata = 32'(lvdt_q);
      dcw_pkg::REG_AXIS_ONE: prdata = 32'(axis_one_q);
      dcw_pkg::REG_AXIS_TWO: prdata = 32'(axis_two_q);
      default:               prdata = '0;
    endcase
  end

  dcw_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .op_i      (s_axis_tuser[0]),
    .channel_i (s_axis_tdata[2:0]),
    .value_i   ($signed(s_axis_tdata[18:3])),
    .volt_i    (s_axis_tuser[1]),
    .inc_i     (s_axis_tuser[2]),
    .axis_one_i(axis_one_q),
    .axis_two_i(axis_two_q),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  dcw_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(cmd_valid),
    .data_o (cmd_out)
  );

  dcw_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .DAC_MAX     (DAC_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .pop_o      (pop),
    .null_ofs_i (null_q),
    .lvdt_ofs_i (lvdt_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {6'd0, res.read_value, res.slave_select, res.spi_word};
  assign m_axis_tuser = {res.status, res.spi_send};

  // a rejected channel never reaches the dac
  a_bad_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status |-> !res.spi_send && res.slave_select == 4'd0)
    else $error("bad channel result carries a dac word");

  // every dac word carries the update bit
  a_update_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.spi_send |-> res.spi_word[14])
    else $error("dac word without update bit");

  // a write never returns read-back data
  a_write_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.spi_send |-> res.read_value == 15'sd0 && !res.status)
    else $error("write result carries read-back data");

  // the command queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("command queue overflow");

endmodule

// File: tb/dac_channel_writer_tb.sv
`timescale 1ns / 1ps

module dac_channel_writer_tb;

  localparam int NUM_CHANNELS   = 4;
  localparam int DAC_MAX        = 16383;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic               op;
    logic [2:0]         ch;
    logic signed [15:0] value;
    logic               volt;
    logic               inc;
  } dac_cmd_t;

  typedef struct packed {
    logic               spi_send;
    logic [14:0]        spi_word;
    logic [3:0]         slave_select;
    logic signed [14:0] read_value;
    logic               status;
  } dac_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  dac_channel_writer #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .DAC_MAX     (DAC_MAX)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block's registers and stored codes
  logic signed [14:0] null_ofs_mv = '0;
  logic signed [14:0] lvdt_ofs_mv = '0;
  logic [2:0]         axis_one_ch = 3'd1;
  logic [2:0]         axis_two_ch = 3'd2;
  logic [13:0]        chan_codes [NUM_CHANNELS] = '{default: '0};

  dac_cmd_t    queued_cmds [$];
  dac_result_t due_results [$];
  dac_cmd_t    held_cmd;
  logic        item_held = 1'b0;
  int          send_idle_pct = 7;
  int          recv_stall_pct = 69;
  logic        hold_req = 1'b0;
  int          hold_count = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  function automatic longint mv_of_code(input longint code);
    return ((code - dcw_pkg::MID_CODE) * dcw_pkg::MV_FULL) / dcw_pkg::MID_CODE;
  endfunction

  function automatic longint counts_of_mv(input longint mv);
    return (dcw_pkg::CODE_PER_V * mv) / dcw_pkg::MV_PER_V;
  endfunction

  function automatic longint clamp_dac(input longint code);
    if (code > DAC_MAX) return DAC_MAX;
    if (code < 0) return 0;
    return code;
  endfunction

  // result of one beat; updates the stored channel codes on a good write
  function automatic dac_result_t dac_step_result(input dac_cmd_t c);
    dac_result_t r;
    longint      code;
    longint      v;
    int          slot;
    r = '0;
    if (c.ch < 1 || c.ch > NUM_CHANNELS) begin
      r.status = 1'b1;
      return r;
    end
    slot = c.ch - 1;
    if (c.op == dcw_pkg::OP_READ) begin
      v = c.volt ? mv_of_code(longint'(chan_codes[slot])) : longint'(chan_codes[slot]);
      r.read_value = v[14:0];
      return r;
    end
    v = c.value;
    if (c.volt) begin
      if (c.inc) v += mv_of_code(longint'(chan_codes[slot]));
      code = dcw_pkg::MID_CODE + counts_of_mv(v);
    end else begin
      code = v;
      if (c.inc) code += longint'(chan_codes[slot]);
    end
    code = clamp_dac(code);
    chan_codes[slot] = code[13:0];
    // offsets go in once even when both axis registers name this channel
    if (c.ch == axis_one_ch || c.ch == axis_two_ch) begin
      code += counts_of_mv(null_ofs_mv) + counts_of_mv(lvdt_ofs_mv);
      code = clamp_dac(code);
    end
    r.spi_send     = 1'b1;
    r.spi_word     = code[14:0] | dcw_pkg::UPDATE_BIT;
    r.slave_select = 4'(1 << slot);
    return r;
  endfunction

  function automatic dac_cmd_t mk_cmd(input logic op, input int ch, input int value,
                                      input logic volt, input logic inc);
    dac_cmd_t c;
    c.op    = op;
    c.ch    = 3'(ch);
    c.value = 16'(value);
    c.volt  = volt;
    c.inc   = inc;
    return c;
  endfunction

  function automatic dac_cmd_t rand_cmd();
    int tmp;
    int ch;
    ch = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
    case ($urandom_range(3))
      0:       tmp = $urandom_range(65535);
      1:       tmp = int'($urandom_range(20000)) - 10000;
      2:       tmp = $urandom_range(DAC_MAX);
      default: tmp = int'($urandom_range(1000)) - 500;
    endcase
    return mk_cmd(($urandom_range(99) < 35) ? dcw_pkg::OP_READ : dcw_pkg::OP_WRITE, ch, tmp,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(dac_step_result(held_cmd));
        item_held = 1'b0;
      end
      if (!item_held && queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        held_cmd = queued_cmds.pop_front();
        item_held = 1'b1;
        s_axis_tdata <= {5'b0, held_cmd.value, held_cmd.ch};
        s_axis_tuser <= {held_cmd.inc, held_cmd.volt, held_cmd.op};
      end
      s_axis_tvalid <= item_held;
    end
  end

  // result side
  always @(posedge clk_i) begin
    dac_result_t got;
    dac_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.spi_word     = m_axis_tdata[14:0];
        got.slave_select = m_axis_tdata[18:15];
        got.read_value   = m_axis_tdata[33:19];
        got.spi_send     = m_axis_tuser[0];
        got.status       = m_axis_tuser[1];
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: send %0b word %h sel %b rd %0d status %0b",
                     got.spi_send, got.spi_word, got.slave_select, got.read_value,
                     got.status);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result mismatch: exp send %0b word %h sel %b rd %0d status %0b",
                       want.spi_send, want.spi_word, want.slave_select, want.read_value,
                       want.status);
              $display("                 got send %0b word %h sel %b rd %0d status %0b",
                       got.spi_send, got.spi_word, got.slave_select, got.read_value,
                       got.status);
            end
          end
        end
      end
      // one long hold-off so the command queue fills and input backs up
      if (hold_req && hold_count < HOLD_CYCLES) begin
        hold_count++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (queued_cmds.size() != 0 || item_held || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(data);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dcw_pkg::REG_NULL_OFS: null_ofs_mv = data[14:0];
      dcw_pkg::REG_LVDT_OFS: lvdt_ofs_mv = data[14:0];
      dcw_pkg::REG_AXIS_ONE: axis_one_ch = data[2:0];
      dcw_pkg::REG_AXIS_TWO: axis_two_ch = data[2:0];
      default: ;
    endcase
  endtask

  task automatic run_setting(input int null_mv, input int lvdt_mv, input int ax1,
                             input int ax2, input int n_items);
    wait_drained();
    write_reg(dcw_pkg::REG_NULL_OFS, null_mv);
    write_reg(dcw_pkg::REG_LVDT_OFS, lvdt_mv);
    write_reg(dcw_pkg::REG_AXIS_ONE, ax1);
    write_reg(dcw_pkg::REG_AXIS_TWO, ax2);
    repeat (n_items) queued_cmds.push_back(rand_cmd());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: raw extremes, clamping, read-backs, increments, bad channels
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 1, 0, 1'b0, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 2, DAC_MAX, 1'b0, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 3, 32767, 1'b0, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 4, -32768, 1'b0, 1'b0));
    for (int ch = 1; ch <= NUM_CHANNELS; ch++)
      queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, ch, 0, 1'b0, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, 2, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 1, 32767, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 2, -32768, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 3, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 3, 1000, 1'b1, 1'b1));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 3, -100, 1'b0, 1'b1));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 4, 32767, 1'b0, 1'b1));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, 3, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, 4, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 0, 1234, 1'b0, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, 5, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 7, -1, 1'b1, 1'b1));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, 1, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 4, -10000, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_READ, 4, 0, 1'b1, 1'b0));
    queued_cmds.push_back(mk_cmd(dcw_pkg::OP_WRITE, 2, -32768, 1'b1, 1'b1));

    run_setting(10000, 10000, 3, 4, 400);

    wait_drained();
    send_idle_pct  = 69;
    recv_stall_pct = 7;
    run_setting(-10000, 2500, 4, 0, 400);

    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    run_setting(int'($urandom_range(20000)) - 10000, int'($urandom_range(20000)) - 10000,
                2, 2, 400);

    run_setting(int'($urandom_range(20000)) - 10000, -10000, 7, 1, 400);

    wait_drained();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dcw_pkg.sv
rtl/dcw_front.sv
rtl/dcw_fifo.sv
rtl/dcw_m2c.sv
rtl/dcw_back.sv
rtl/dac_channel_writer.sv
tb/dac_channel_writer_tb.sv
